// ===== hdl/scbs_pkg.sv =====
// ---------------------------------------------------------------------------
// Signal countdown bar sequencer package
// Widths, register indexes and helper functions shared by the sequencer.
// ---------------------------------------------------------------------------
package scbs_pkg;

   // Bar display geometry
   localparam int BAR_COUNT = 5;
   localparam int BAR_W     = 5;
   localparam int LEVEL_W   = 3;

   // Counter and register widths
   localparam int YELLOW_W  = 6;
   localparam int TICK_W    = 8;
   localparam int UNIT_W    = 8;
   localparam int BOTH_W    = 8;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   // Stream words
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;

   // Register reset values
   localparam logic [YELLOW_W-1:0] WINDOW_LOW_RESET     = YELLOW_W'(15);
   localparam logic [YELLOW_W-1:0] WINDOW_HIGH_RESET    = YELLOW_W'(26);
   localparam logic [YELLOW_W-1:0] HOLD_TICKS_RESET     = YELLOW_W'(28);
   localparam logic [TICK_W-1:0]   TICKS_PER_UNIT_RESET = TICK_W'(25);
   localparam logic [UNIT_W-1:0]   RED_UNITS_RESET      = UNIT_W'(30);
   localparam logic [UNIT_W-1:0]   GREEN_UNITS_RESET    = UNIT_W'(18);
   localparam logic [BOTH_W-1:0]   BOTH_ON_RESET        = BOTH_W'(25);

   localparam logic [LEVEL_W-1:0] LEVEL_FULL  = LEVEL_W'(BAR_COUNT);
   localparam logic [LEVEL_W-1:0] RED_FLOOR   = LEVEL_W'(1);
   localparam logic [LEVEL_W-1:0] GREEN_FLOOR = LEVEL_W'(0);

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WINDOW_LOW     = 3'd0,
      CSR_WINDOW_HIGH    = 3'd1,
      CSR_HOLD_TICKS     = 3'd2,
      CSR_TICKS_PER_UNIT = 3'd3,
      CSR_RED_UNITS      = 3'd4,
      CSR_GREEN_UNITS    = 3'd5,
      CSR_BOTH_ON_TICKS  = 3'd6
   } csr_index_type;

   // State of one lamp countdown
   typedef struct packed {
      logic [TICK_W-1:0]  ticks;
      logic [UNIT_W-1:0]  units;
      logic [LEVEL_W-1:0] level;
   } countdown_type;

   // One tick of a lamp countdown: ticks into units, units into level steps; an unlit or unarmed lamp restarts at full.
   function automatic countdown_type countdown_step(
      input logic               lit,
      input logic               armed,
      input countdown_type      cur,
      input logic [TICK_W-1:0]  ticks_per_unit,
      input logic [UNIT_W-1:0]  units_per_step,
      input logic [LEVEL_W-1:0] floor_level
   );
      countdown_type nxt;
      nxt = cur;
      if (lit && armed) begin
         nxt.ticks = cur.ticks + TICK_W'(1);
         if (nxt.ticks == ticks_per_unit) begin
            nxt.ticks = '0;
            nxt.units = cur.units + UNIT_W'(1);
            if (nxt.units == units_per_step) begin
               nxt.units = '0;
               nxt.level = (cur.level > LEVEL_W'(1)) ? cur.level - LEVEL_W'(1)
                                                     : floor_level;
            end
         end
      end else begin
         nxt.ticks = '0;
         nxt.units = '0;
         nxt.level = LEVEL_FULL;
      end
      return nxt;
   endfunction

   // Thermometer code: bar i lights when the level is above i.
   function automatic logic [BAR_W-1:0] bar_pattern(input logic [LEVEL_W-1:0] level);
      logic [BAR_W-1:0] pat;
      for (int i = 0; i < BAR_W; i++) begin
         pat[i] = (i < BAR_COUNT) && (level > LEVEL_W'(i));
      end
      return pat;
   endfunction

endpackage

// ===== hdl/signal_countdown_bar_sequencer.sv =====
// ---------------------------------------------------------------------------
// Signal countdown bar sequencer
// Turns sampled traffic lamp levels into green and red countdown bar
// patterns and a yellow hold disc, one result word per tick word.
// ---------------------------------------------------------------------------
// Usage:
//  - req_*: one word per 4 ms tick with the sensed green, red and yellow lamps.
//  - rsp_*: one word per tick word with both bar patterns and the yellow disc.
//  - csr_*: register writes, always ready; write only while the block is idle.
// The result of a tick word is registered and offered on rsp_* from the edge
// that accepts the word. Throughput is one word per cycle while the
// receiver takes each result; the whole tick update is a single pass of
// counter compares and small muxes feeding the state registers, result included.
// The result register doubles as the skid stage: req_tready stays high while
// the result slot is empty or being taken, so a stalled receiver holds the
// pending result and stops input only for as long as it stalls.
// Reset (synchronous, active high) restores the register defaults, clears
// all counters, arms and bars, sets both levels to full and drops rsp_tvalid.
// ---------------------------------------------------------------------------
module signal_countdown_bar_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   // Tick words: [0] green_lamp, [1] red_lamp, [2] yellow_lamp
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [scbs_pkg::REQ_DATA_W-1:0]     req_tdata,
   // Results: [4:0] green_bar_pattern, [9:5] red_bar_pattern, [10] yellow_disc
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [scbs_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // Register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [scbs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [scbs_pkg::CSR_DATA_W-1:0]     csr_data
);
   import scbs_pkg::*;

   // Configuration registers
   logic [YELLOW_W-1:0] window_low_ff, window_high_ff, hold_ticks_ff;
   logic [TICK_W-1:0]   ticks_per_unit_ff;
   logic [UNIT_W-1:0]   red_units_ff, green_units_ff;
   logic [BOTH_W-1:0]   both_on_ticks_ff;

   // Tick state and its next value
   logic [YELLOW_W-1:0] yellow_ticks_ff, yellow_ticks_in;
   logic                green_armed_ff, green_armed_in;
   logic                red_armed_ff, red_armed_in;
   countdown_type       red_cd_ff, red_cd_in;
   countdown_type       green_cd_ff, green_cd_in;
   logic [BOTH_W-1:0]   both_on_count_ff, both_on_count_in;
   logic                both_on_flag_ff, both_on_flag_in;
   logic                holding_ff, holding_in;
   logic [BAR_W-1:0]    green_bars_ff, green_bars_in;
   logic [BAR_W-1:0]    red_bars_ff, red_bars_in;
   logic                rsp_valid_ff;

   logic green_lamp, red_lamp, yellow_lamp;
   logic run_rest;
   logic req_accept;

   assign green_lamp  = req_tdata[0];
   assign red_lamp    = req_tdata[1];
   assign yellow_lamp = req_tdata[2];

   // The result slot is free when empty or being emptied this cycle.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Configuration writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_low_ff     <= WINDOW_LOW_RESET;
         window_high_ff    <= WINDOW_HIGH_RESET;
         hold_ticks_ff     <= HOLD_TICKS_RESET;
         ticks_per_unit_ff <= TICKS_PER_UNIT_RESET;
         red_units_ff      <= RED_UNITS_RESET;
         green_units_ff    <= GREEN_UNITS_RESET;
         both_on_ticks_ff  <= BOTH_ON_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WINDOW_LOW:     window_low_ff     <= csr_data[YELLOW_W-1:0];
            CSR_WINDOW_HIGH:    window_high_ff    <= csr_data[YELLOW_W-1:0];
            CSR_HOLD_TICKS:     hold_ticks_ff     <= csr_data[YELLOW_W-1:0];
            CSR_TICKS_PER_UNIT: ticks_per_unit_ff <= csr_data[TICK_W-1:0];
            CSR_RED_UNITS:      red_units_ff      <= csr_data[UNIT_W-1:0];
            CSR_GREEN_UNITS:    green_units_ff    <= csr_data[UNIT_W-1:0];
            CSR_BOTH_ON_TICKS:  both_on_ticks_ff  <= csr_data[BOTH_W-1:0];
            default: ;
         endcase
      end
   end

   // Tick update: yellow rules, countdowns, both-on rule, then the display.
   always_comb begin
      yellow_ticks_in  = yellow_ticks_ff;
      green_armed_in   = green_armed_ff;
      red_armed_in     = red_armed_ff;
      red_cd_in        = red_cd_ff;
      green_cd_in      = green_cd_ff;
      both_on_count_in = both_on_count_ff;
      both_on_flag_in  = both_on_flag_ff;
      holding_in       = holding_ff;
      green_bars_in    = green_bars_ff;
      red_bars_in      = red_bars_ff;
      run_rest         = 1'b1;

      if (holding_ff) begin
         // Hold lasts while yellow stays lit; the first dark tick runs normally.
         if (yellow_lamp) begin
            run_rest = 1'b0;
         end else begin
            holding_in = 1'b0;
         end
      end else if (yellow_lamp) begin
         if (yellow_ticks_ff != '1) begin
            yellow_ticks_in = yellow_ticks_ff + YELLOW_W'(1);
         end
         if (yellow_ticks_in >= window_low_ff && yellow_ticks_in <= window_high_ff
             && green_lamp) begin
            yellow_ticks_in = '0;
            green_armed_in  = 1'b1;
         end
         if (yellow_ticks_in >= window_low_ff && yellow_ticks_in <= window_high_ff
             && red_lamp) begin
            yellow_ticks_in = '0;
            red_armed_in    = 1'b1;
         end
         // A long yellow enters hold; levels go to full, tick and unit counts keep their values.
         if (yellow_ticks_in >= hold_ticks_ff) begin
            green_bars_in     = '0;
            yellow_ticks_in   = '0;
            green_armed_in    = 1'b0;
            red_armed_in      = 1'b0;
            red_cd_in.level   = LEVEL_FULL;
            green_cd_in.level = LEVEL_FULL;
            both_on_flag_in   = 1'b0;
            holding_in        = 1'b1;
            run_rest          = 1'b0;
         end
      end else begin
         yellow_ticks_in = '0;
      end

      if (run_rest) begin
         red_cd_in   = countdown_step(red_lamp, red_armed_in, red_cd_ff,
                                      ticks_per_unit_ff, red_units_ff, RED_FLOOR);
         green_cd_in = countdown_step(green_lamp, green_armed_in, green_cd_ff,
                                      ticks_per_unit_ff, green_units_ff, GREEN_FLOOR);

         // Both lamps lit long enough blanks the bars until the next hold.
         if (green_lamp && red_lamp) begin
            both_on_count_in = both_on_count_ff + BOTH_W'(1);
            if (both_on_count_in == both_on_ticks_ff) begin
               both_on_count_in = '0;
               both_on_flag_in  = 1'b1;
            end
         end else begin
            both_on_count_in = '0;
         end

         // Green display first, then red against the green result.
         if (green_lamp) begin
            if (both_on_flag_in) begin
               green_bars_in = '0;
            end else if (green_cd_in.level >= LEVEL_FULL) begin
               red_bars_in   = '0;
               green_bars_in = bar_pattern(LEVEL_FULL);
            end else begin
               green_bars_in = bar_pattern(green_cd_in.level);
            end
         end
         if (red_lamp) begin
            if (both_on_flag_in) begin
               red_bars_in = '0;
            end else if (red_cd_in.level >= LEVEL_FULL) begin
               green_bars_in = '0;
               red_bars_in   = bar_pattern(LEVEL_FULL);
            end else begin
               red_bars_in = bar_pattern(red_cd_in.level);
            end
         end
      end
   end

   // State registers; the bars and hold flag also form the result word.
   always_ff @(posedge clock) begin
      if (reset) begin
         yellow_ticks_ff  <= '0;
         green_armed_ff   <= 1'b0;
         red_armed_ff     <= 1'b0;
         red_cd_ff        <= '{ticks: '0, units: '0, level: LEVEL_FULL};
         green_cd_ff      <= '{ticks: '0, units: '0, level: LEVEL_FULL};
         both_on_count_ff <= '0;
         both_on_flag_ff  <= 1'b0;
         holding_ff       <= 1'b0;
         green_bars_ff    <= '0;
         red_bars_ff      <= '0;
      end else if (req_accept) begin
         yellow_ticks_ff  <= yellow_ticks_in;
         green_armed_ff   <= green_armed_in;
         red_armed_ff     <= red_armed_in;
         red_cd_ff        <= red_cd_in;
         green_cd_ff      <= green_cd_in;
         both_on_count_ff <= both_on_count_in;
         both_on_flag_ff  <= both_on_flag_in;
         holding_ff       <= holding_in;
         green_bars_ff    <= green_bars_in;
         red_bars_ff      <= red_bars_in;
      end
   end

   // Result word valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - 2 * BAR_W - 1)'(0), holding_ff,
                        red_bars_ff, green_bars_ff};

   // Checks on the sequencer's own state.
   a_hold_blanks_green: assert property (@(posedge clock) disable iff (reset)
      holding_ff |-> (green_bars_ff == '0))
      else $error("green bars lit during yellow hold");

   a_hold_clears_yellow: assert property (@(posedge clock) disable iff (reset)
      holding_ff |-> (yellow_ticks_ff == '0 && !green_armed_ff && !red_armed_ff))
      else $error("yellow count or arms left set during hold");

   a_red_level_range: assert property (@(posedge clock) disable iff (reset)
      (red_cd_ff.level != '0) && (red_cd_ff.level <= LEVEL_FULL))
      else $error("red level out of range");

   a_green_level_range: assert property (@(posedge clock) disable iff (reset)
      green_cd_ff.level <= LEVEL_FULL)
      else $error("green level out of range");

   a_state_only_on_accept: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(holding_ff) && $stable(green_bars_ff)
                      && $stable(red_bars_ff))
      else $error("state changed without an accepted tick word");

endmodule
